// ----- rtl/hcbd_pkg.sv -----
// Package with the shared types and constants of the chunked body decoder.
package hcbd_pkg;

  localparam int LENGTH_BITS_DEF = 32;

  localparam logic [7:0] CH_CR = 8'h0D;
  localparam logic [7:0] CH_LF = 8'h0A;

  typedef enum logic [1:0] {
    KIND_PAYLOAD = 2'd0,
    KIND_END     = 2'd1,
    KIND_ERROR   = 2'd2
  } kind_t;

  typedef enum logic [6:0] {
    PH_SIZE      = 7'b0000001,
    PH_EXT       = 7'b0000010,
    PH_AWAIT_LF  = 7'b0000100,
    PH_DATA      = 7'b0001000,
    PH_LEAD_SKIP = 7'b0010000,
    PH_DONE      = 7'b0100000,
    PH_ERROR     = 7'b1000000
  } phase_t;

  typedef struct packed {
    logic       is_cr;
    logic       is_lf;
    logic       is_hex;
    logic [3:0] digit;
  } byte_class_t;

  typedef struct packed {
    logic [7:0] payload_byte;
    logic [1:0] kind;
    logic       chunk_last;
  } result_t;

endpackage

// ----- rtl/hcbd_if.sv -----
// Valid/ready channel interfaces for the input bytes and the decoded results.
interface hcbd_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] in_byte;

  modport source (output valid, output in_byte, input ready);
  modport sink (input valid, input in_byte, output ready);
endinterface

interface hcbd_out_if;
  logic       valid;
  logic       ready;
  logic [7:0] payload_byte;
  logic [1:0] kind;
  logic       chunk_last;

  modport source (output valid, output payload_byte, output kind, output chunk_last,
                  input ready);
  modport sink (input valid, input payload_byte, input kind, input chunk_last,
                output ready);
endinterface

// ----- rtl/hcbd_classify.sv -----
// Byte classifier: flags CR, LF and hex digits and gives the digit value.
module hcbd_classify (
  input  logic [7:0]                in_byte,
  output hcbd_pkg::byte_class_t     cls
);
  import hcbd_pkg::*;

  always_comb begin
    cls.is_cr  = (in_byte == CH_CR);
    cls.is_lf  = (in_byte == CH_LF);
    cls.is_hex = 1'b0;
    cls.digit  = 4'd0;
    if (in_byte >= 8'h30 && in_byte <= 8'h39) begin
      cls.is_hex = 1'b1;
      cls.digit  = 4'(in_byte - 8'h30);
    end else if (in_byte >= 8'h61 && in_byte <= 8'h66) begin
      cls.is_hex = 1'b1;
      cls.digit  = 4'(in_byte - 8'h57);
    end else if (in_byte >= 8'h41 && in_byte <= 8'h46) begin
      cls.is_hex = 1'b1;
      cls.digit  = 4'(in_byte - 8'h37);
    end
  end

endmodule

// ----- rtl/hcbd_parser.sv -----
// Parse state machine: size line parsing, payload counting, end and error detection.
module hcbd_parser #(
  parameter int LENGTH_BITS = hcbd_pkg::LENGTH_BITS_DEF
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  fire,
  input  logic [7:0]            in_byte,
  input  hcbd_pkg::byte_class_t cls,
  output logic                  res_valid,
  output hcbd_pkg::result_t     res
);
  import hcbd_pkg::*;

  phase_t                 phase_r, phase_nxt;
  logic [LENGTH_BITS-1:0] remaining_r, remaining_nxt;
  logic                   digit_seen_r, digit_seen_nxt;
  logic                   skip_used_r, skip_used_nxt;

  // Next phase for a byte in the text after the digits of a size line.
  phase_t ext_phase;
  assign ext_phase = cls.is_cr ? PH_AWAIT_LF : PH_EXT;

  always_comb begin
    phase_nxt      = phase_r;
    remaining_nxt  = remaining_r;
    digit_seen_nxt = digit_seen_r;
    skip_used_nxt  = skip_used_r;
    res_valid      = 1'b0;
    res            = '0;
    unique case (phase_r)
      PH_SIZE: begin
        if (cls.is_cr) begin
          phase_nxt = (!digit_seen_r && !skip_used_r) ? PH_LEAD_SKIP : PH_AWAIT_LF;
        end else if (cls.is_hex) begin
          // A digit that would shift a nonzero top nibble out overflows the length counter.
          if (remaining_r[LENGTH_BITS-1 -: 4] != 4'd0) begin
            phase_nxt = PH_ERROR;
            res_valid = 1'b1;
            res.kind  = KIND_ERROR;
          end else begin
            remaining_nxt  = {remaining_r[LENGTH_BITS-5:0], cls.digit};
            digit_seen_nxt = 1'b1;
          end
        end else begin
          phase_nxt = PH_EXT;
        end
      end
      PH_LEAD_SKIP: begin
        skip_used_nxt = 1'b1;
        phase_nxt     = cls.is_lf ? PH_SIZE : ext_phase;
      end
      PH_EXT: begin
        phase_nxt = ext_phase;
      end
      PH_AWAIT_LF: begin
        if (!cls.is_lf) begin
          phase_nxt = ext_phase;
        end else if (!digit_seen_r) begin
          phase_nxt = PH_ERROR;
          res_valid = 1'b1;
          res.kind  = KIND_ERROR;
        end else if (remaining_r == '0) begin
          phase_nxt = PH_DONE;
          res_valid = 1'b1;
          res.kind  = KIND_END;
        end else begin
          phase_nxt = PH_DATA;
        end
      end
      PH_DATA: begin
        res_valid        = 1'b1;
        res.payload_byte = in_byte;
        res.kind         = KIND_PAYLOAD;
        if (remaining_r == LENGTH_BITS'(1)) begin
          res.chunk_last = 1'b1;
          phase_nxt      = PH_SIZE;
          remaining_nxt  = '0;
          digit_seen_nxt = 1'b0;
          skip_used_nxt  = 1'b0;
        end else begin
          remaining_nxt = remaining_r - LENGTH_BITS'(1);
        end
      end
      default: begin
        // Done or error: bytes are dropped until reset.
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r      <= PH_SIZE;
      remaining_r  <= '0;
      digit_seen_r <= 1'b0;
      skip_used_r  <= 1'b0;
    end else if (fire) begin
      phase_r      <= phase_nxt;
      remaining_r  <= remaining_nxt;
      digit_seen_r <= digit_seen_nxt;
      skip_used_r  <= skip_used_nxt;
    end
  end

endmodule

// ----- rtl/http_chunked_body_decoder.sv -----
// Chunked body decoder: takes one byte per cycle and delivers at most one result per byte,
// through an input register and then a result register; the input stalls
// only while the result register holds a result the sink has not taken.
module http_chunked_body_decoder #(
  parameter int LENGTH_BITS = hcbd_pkg::LENGTH_BITS_DEF
) (
  input  logic       clk,
  input  logic       rst_n,
  hcbd_in_if.sink    in_ch,
  hcbd_out_if.source out_ch
);
  import hcbd_pkg::*;

  logic        in_valid_r, in_valid_nxt;
  logic [7:0]  in_byte_r;
  logic        out_valid_r, out_valid_nxt;
  result_t     out_res_r;
  logic        adv;
  logic        res_valid;
  result_t     res;
  byte_class_t cls;

  // The held byte moves on whenever the result register can take a new value.
  assign adv          = in_valid_r && (!out_valid_r || out_ch.ready);
  assign in_ch.ready  = !in_valid_r || adv;

  always_comb begin
    in_valid_nxt = in_valid_r;
    if (in_ch.valid && in_ch.ready) begin
      in_valid_nxt = 1'b1;
    end else if (adv) begin
      in_valid_nxt = 1'b0;
    end
    out_valid_nxt = out_valid_r;
    if (adv && res_valid) begin
      out_valid_nxt = 1'b1;
    end else if (out_ch.ready) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      in_valid_r  <= in_valid_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (in_ch.valid && in_ch.ready) begin
      in_byte_r <= in_ch.in_byte;
    end
    if (adv && res_valid) begin
      out_res_r <= res;
    end
  end

  hcbd_classify u_classify (
    .in_byte (in_byte_r),
    .cls     (cls)
  );

  hcbd_parser #(
    .LENGTH_BITS (LENGTH_BITS)
  ) u_parser (
    .clk       (clk),
    .rst_n     (rst_n),
    .fire      (adv),
    .in_byte   (in_byte_r),
    .cls       (cls),
    .res_valid (res_valid),
    .res       (res)
  );

  assign out_ch.valid        = out_valid_r;
  assign out_ch.payload_byte = out_res_r.payload_byte;
  assign out_ch.kind         = out_res_r.kind;
  assign out_ch.chunk_last   = out_res_r.chunk_last;

endmodule

// ----- tb/tb_http_chunked_body_decoder.sv -----
// Self-checking testbench for the chunked body decoder: byte stream stimulus and scoreboard.
module tb_http_chunked_body_decoder;
  timeunit 1ns;
  timeprecision 1ps;

  import hcbd_pkg::*;

  localparam int LEN_W       = LENGTH_BITS_DEF;
  localparam int CYCLE_LIMIT = 400000;
  localparam int BODY_BYTES  = 1290;

  // Predicts the decoder's results byte by byte and checks what comes out.
  class chunk_decode_sb;
    phase_t         line_phase;
    logic [LEN_W-1:0] bytes_left;
    bit             have_digit;
    bit             crlf_skipped;
    result_t        pending_results[$];
    int             errors;

    function new();
      errors = 0;
      start_line();
    endfunction

    static function int hex_nibble(logic [7:0] b);
      if (b >= "0" && b <= "9") return int'(b - "0");
      if (b >= "a" && b <= "f") return int'(b - "a") + 10;
      if (b >= "A" && b <= "F") return int'(b - "A") + 10;
      return -1;
    endfunction

    function void start_line();
      line_phase   = PH_SIZE;
      bytes_left   = '0;
      have_digit   = 1'b0;
      crlf_skipped = 1'b0;
    endfunction

    function void push(logic [7:0] b, kind_t k, logic last);
      result_t r;
      r.payload_byte = b;
      r.kind         = k;
      r.chunk_last   = last;
      pending_results.push_back(r);
    endfunction

    function void ext_byte(logic [7:0] b);
      if (b == CH_CR) line_phase = PH_AWAIT_LF;
      else line_phase = PH_EXT;
    endfunction

    function void decode_byte(logic [7:0] b);
      int nib;
      nib = hex_nibble(b);
      case (line_phase)
        PH_SIZE: begin
          if (b == CH_CR) begin
            if (!have_digit && !crlf_skipped) line_phase = PH_LEAD_SKIP;
            else line_phase = PH_AWAIT_LF;
          end else if (nib >= 0) begin
            // A digit that would shift a nonzero nibble out of the counter is an overflow.
            if (bytes_left[LEN_W-1 -: 4] != 4'h0) begin
              line_phase = PH_ERROR;
              push(8'h00, KIND_ERROR, 1'b0);
            end else begin
              bytes_left = {bytes_left[LEN_W-5:0], nib[3:0]};
              have_digit = 1'b1;
            end
          end else begin
            line_phase = PH_EXT;
          end
        end
        PH_LEAD_SKIP: begin
          crlf_skipped = 1'b1;
          if (b == CH_LF) line_phase = PH_SIZE;
          else ext_byte(b);
        end
        PH_EXT: ext_byte(b);
        PH_AWAIT_LF: begin
          if (b != CH_LF) begin
            ext_byte(b);
          end else if (!have_digit) begin
            line_phase = PH_ERROR;
            push(8'h00, KIND_ERROR, 1'b0);
          end else if (bytes_left == '0) begin
            line_phase = PH_DONE;
            push(8'h00, KIND_END, 1'b0);
          end else begin
            line_phase = PH_DATA;
          end
        end
        PH_DATA: begin
          bytes_left = bytes_left - 1'b1;
          if (bytes_left == '0) begin
            start_line();
            push(b, KIND_PAYLOAD, 1'b1);
          end else begin
            push(b, KIND_PAYLOAD, 1'b0);
          end
        end
        default: ;
      endcase
    endfunction

    function void check_result(result_t got);
      result_t want;
      if (pending_results.size() == 0) begin
        $error("unexpected result: payload_byte %0h kind %0d chunk_last %0d",
               got.payload_byte, got.kind, got.chunk_last);
        errors++;
        return;
      end
      want = pending_results.pop_front();
      if (got.payload_byte !== want.payload_byte) begin
        $error("payload_byte: expected %0h, got %0h", want.payload_byte, got.payload_byte);
        errors++;
      end
      if (got.kind !== want.kind) begin
        $error("kind: expected %0d, got %0d", want.kind, got.kind);
        errors++;
      end
      if (got.chunk_last !== want.chunk_last) begin
        $error("chunk_last: expected %0d, got %0d", want.chunk_last, got.chunk_last);
        errors++;
      end
    endfunction

    function int pending();
      return pending_results.size();
    endfunction
  endclass

  logic clk = 1'b0;
  logic rst_n;
  int   cycle_cnt = 0;

  hcbd_in_if  in_ch();
  hcbd_out_if out_ch();

  http_chunked_body_decoder dut (
    .clk   (clk),
    .rst_n (rst_n),
    .in_ch (in_ch),
    .out_ch(out_ch)
  );

  chunk_decode_sb sb = new();
  logic [7:0]     stream_q[$];

  always #5 clk = ~clk;

  always @(posedge clk) begin
    cycle_cnt++;
    if (cycle_cnt > CYCLE_LIMIT) begin
      $display("DONE: errors detected");
      $finish;
    end
  end

  // Every transfer on either channel goes to the scoreboard.
  always @(posedge clk) begin
    if (rst_n && in_ch.valid && in_ch.ready) sb.decode_byte(in_ch.in_byte);
  end

  always @(posedge clk) begin
    result_t got;
    if (rst_n && out_ch.valid && out_ch.ready) begin
      got.payload_byte = out_ch.payload_byte;
      got.kind         = out_ch.kind;
      got.chunk_last   = out_ch.chunk_last;
      sb.check_result(got);
    end
  end

  // Result side back-pressure: short and long stalls, with stall-free stretches.
  initial begin
    int stall_left;
    int mode_left;
    bit free_run;
    stall_left   = 0;
    mode_left    = 0;
    free_run     = 1'b0;
    out_ch.ready = 1'b0;
    forever begin
      @(negedge clk);
      if (mode_left == 0) begin
        free_run  = ($urandom_range(0, 2) == 0);
        mode_left = $urandom_range(50, 300);
      end
      mode_left--;
      if (stall_left > 0) begin
        out_ch.ready = 1'b0;
        stall_left--;
      end else begin
        out_ch.ready = 1'b1;
        if (!free_run && $urandom_range(0, 99) < 20) begin
          if ($urandom_range(0, 9) == 0) stall_left = $urandom_range(8, 40);
          else stall_left = $urandom_range(1, 3);
        end
      end
    end
  end

  function automatic void put_byte(logic [7:0] b);
    stream_q.push_back(b);
  endfunction

  function automatic void put_str(string s);
    for (int i = 0; i < s.len(); i++) stream_q.push_back(s[i]);
  endfunction

  function automatic void put_crlf();
    stream_q.push_back(CH_CR);
    stream_q.push_back(CH_LF);
  endfunction

  function automatic logic [7:0] hex_char(int v);
    string      digits;
    logic [7:0] c;
    digits = "0123456789abcdef";
    c = digits[v];
    if (v > 9 && $urandom_range(0, 1) == 1) c = c - 8'h20;
    return c;
  endfunction

  function automatic void put_zeros(int max_n);
    int n;
    n = ($urandom_range(0, 3) == 0) ? $urandom_range(1, max_n) : 0;
    repeat (n) put_byte("0");
  endfunction

  // Size line text after the digits; may open with a lone CR and may carry hex digits.
  function automatic void put_extension();
    logic [7:0] b;
    int         n;
    if ($urandom_range(0, 3) == 0) begin
      put_byte(CH_CR);
      do b = 8'($urandom_range(0, 255)); while (b == CH_LF || b == CH_CR);
      put_byte(b);
    end else begin
      do b = 8'($urandom_range(0, 255));
      while (b == CH_CR || chunk_decode_sb::hex_nibble(b) >= 0);
      put_byte(b);
    end
    n = $urandom_range(0, 8);
    repeat (n) begin
      if ($urandom_range(0, 7) == 0) begin
        put_byte(CH_CR);
        do b = 8'($urandom_range(0, 255)); while (b == CH_LF || b == CH_CR);
      end else begin
        do b = 8'($urandom_range(0, 255)); while (b == CH_CR);
      end
      put_byte(b);
    end
  endfunction

  function automatic void put_size_line(int unsigned size);
    string digits;
    put_zeros(10);
    digits = $sformatf("%0h", size);
    for (int i = 0; i < digits.len(); i++)
      put_byte(hex_char(chunk_decode_sb::hex_nibble(digits[i])));
    if ($urandom_range(0, 2) == 0) put_extension();
    put_crlf();
  endfunction

  function automatic void put_chunk();
    int unsigned size;
    int          r;
    r = $urandom_range(0, 99);
    if (r < 85) size = $urandom_range(1, 16);
    else if (r < 97) size = $urandom_range(17, 64);
    else size = $urandom_range(65, 300);
    if ($urandom_range(0, 4) != 0) put_crlf();
    put_size_line(size);
    repeat (size) put_byte(8'($urandom_range(0, 255)));
  endfunction

  // The body ends once per run, so each seed picks one way to end it.
  function automatic void put_body_end();
    case ($urandom_range(0, 5))
      0, 1: begin
        if ($urandom_range(0, 1) == 1) put_crlf();
        put_size_line(0);
      end
      2: begin
        put_crlf();
        put_zeros(6);
        put_byte(hex_char($urandom_range(1, 15)));
        repeat (8) put_byte(hex_char($urandom_range(0, 15)));
        put_crlf();
      end
      3: begin
        put_crlf();
        put_crlf();
      end
      4: begin
        put_crlf();
        put_str(" 5");
        put_crlf();
      end
      default: begin
        put_byte(CH_CR);
        put_str("X5");
        put_crlf();
      end
    endcase
    // Trailing bytes after the end must be swallowed without results.
    repeat (20) put_byte(8'($urandom_range(0, 255)));
  endfunction

  task automatic idle_in(int n);
    if (n > 0) begin
      @(negedge clk);
      in_ch.valid = 1'b0;
      repeat (n - 1) @(negedge clk);
    end
  endtask

  task automatic send_byte(logic [7:0] b);
    @(negedge clk);
    in_ch.valid   = 1'b1;
    in_ch.in_byte = b;
    do @(posedge clk); while (!in_ch.ready);
  endtask

  initial begin
    int pause_at;
    int burst_left;
    bit burst;
    int r;
    rst_n         = 1'b0;
    in_ch.valid   = 1'b0;
    in_ch.in_byte = 8'h00;
    burst_left    = 0;
    burst         = 1'b0;

    // Leading line break skip, leading zeros with an extension, a lone CR in a size line,
    // a size line with no preceding line break, and extreme byte values as payload.
    put_crlf();
    put_str("0001;f");
    put_crlf();
    put_byte(8'h00);
    put_crlf();
    put_str("2");
    put_byte(CH_CR);
    put_str("Z");
    put_crlf();
    put_byte(8'hFF);
    put_byte(CH_LF);
    put_str("1");
    put_byte(CH_CR);
    put_crlf();
    put_byte(CH_CR);

    while (stream_q.size() < BODY_BYTES) put_chunk();
    put_body_end();
    pause_at = stream_q.size() / 2;

    repeat (9) @(negedge clk);
    rst_n = 1'b1;

    for (int i = 0; i < stream_q.size(); i++) begin
      if (i == pause_at) begin
        @(negedge clk);
        in_ch.valid = 1'b0;
        while (sb.pending() != 0) @(posedge clk);
      end
      if (burst_left == 0) begin
        burst      = ($urandom_range(0, 2) == 0);
        burst_left = $urandom_range(40, 160);
      end
      burst_left--;
      if (!burst) begin
        r = $urandom_range(0, 99);
        if (r >= 92) idle_in($urandom_range(8, 40));
        else if (r >= 65) idle_in($urandom_range(1, 3));
      end
      send_byte(stream_q[i]);
    end
    @(negedge clk);
    in_ch.valid = 1'b0;

    while (sb.pending() != 0) @(posedge clk);
    repeat (20) @(posedge clk);
    if (sb.errors == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

endmodule

// ----- filelist.f -----
rtl/hcbd_pkg.sv
rtl/hcbd_if.sv
rtl/hcbd_classify.sv
rtl/hcbd_parser.sv
rtl/http_chunked_body_decoder.sv
tb/tb_http_chunked_body_decoder.sv
